>>> sv/pcl_pkg.sv
// pcl_pkg: constants, codes and types for the positional byte list
// used by pcl_store and positional_char_list; no dependencies
package pcl_pkg;

   localparam int CAPACITY = 64;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int LEN_W    = $clog2(CAPACITY + 1);

   localparam logic [1:0] KIND_ADD    = 2'd0;
   localparam logic [1:0] KIND_DELETE = 2'd1;
   localparam logic [1:0] KIND_GET    = 2'd2;
   localparam logic [1:0] KIND_LIST   = 2'd3;

   localparam logic [2:0] ST_VALUE   = 3'd0;
   localparam logic [2:0] ST_INVALID = 3'd1;
   localparam logic [2:0] ST_FULL    = 3'd2;
   localparam logic [2:0] ST_ELEMENT = 3'd3;
   localparam logic [2:0] ST_EMPTY   = 3'd4;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RESP,
      S_GET,
      S_LIST,
      S_SHIFT
   } state_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [7:0]        wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } mem_req_type;

endpackage

>>> sv/pcl_store.sv
// pcl_store: item memory, one write and one read port, registered read data
// depends on pcl_pkg
module pcl_store (
   input  logic                clock,
   input  pcl_pkg::mem_req_type mem_req,
   output logic [7:0]          rd_data
);

   logic [7:0] mem_ff [pcl_pkg::CAPACITY];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/positional_char_list.sv
// positional_char_list: ordered byte list with add, delete, get and list
// depends on pcl_pkg and pcl_store
//
// usage
// req_ beats carry kind, position (one-based) and new_item; rsp_ beats carry
// status, value and last. both channels are valid/ready. one request is
// worked on at a time; req_ready is high only while the block is idle.
// items live in a single-port-write, single-port-read memory of CAPACITY
// bytes with registered read data; add and delete move entries one per
// cycle through that memory, and req_ready stays low until the entries
// have moved and the length is updated; neither gives a response beat.
// get: memory read issued as the request is taken, beat loaded from S_GET.
// list: one beat per cycle per element while rsp_ready is high, last set
// on the final element; an empty list gives one empty beat.
// an invalid position or an add to a full list gives one beat with last set.
// a result waits in the rsp_ output register while rsp_ready is low; the
// sequencer holds any next beat, with the memory read data kept, until it goes.
// reset empties the list; the memory itself is not cleared.
module positional_char_list (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_kind,
   input  logic [6:0] req_position,
   input  logic [7:0] req_new_item,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_status,
   output logic [7:0] rsp_value,
   output logic       rsp_last
);

   localparam int AW = pcl_pkg::ADDR_W;
   localparam int LW = pcl_pkg::LEN_W;

   pcl_pkg::state_type   state_ff, state_in;
   logic [LW-1:0]        len_ff, len_in;
   logic [LW-1:0]        cnt_ff, cnt_in;
   logic [LW-1:0]        idx_ff, idx_in;
   logic [AW-1:0]        rd_ff, rd_in;
   logic [AW-1:0]        wr_addr_ff, wr_addr_in;
   logic                 wr_pend_ff, wr_pend_in;
   logic                 op_add_ff, op_add_in;
   logic [AW-1:0]        pos_addr_ff, pos_addr_in;
   logic [7:0]           item_ff, item_in;
   logic [2:0]           resp_status_ff, resp_status_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [2:0]           rsp_status_ff, rsp_status_in;
   logic [7:0]           rsp_value_ff, rsp_value_in;
   logic                 rsp_last_ff, rsp_last_in;

   pcl_pkg::mem_req_type mem_req;
   logic [7:0]           rd_data;

   logic                 out_free;
   logic                 rsp_load;
   logic [7:0]           pos8, len8;
   logic [6:0]           pos_m1;
   logic [LW-1:0]        len_m1;
   logic [LW-1:0]        idx_next;
   logic                 add_bad, acc_bad, is_full;

   pcl_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   assign req_ready  = (state_ff == pcl_pkg::S_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign pos8       = {1'b0, req_position};
   assign len8       = 8'(len_ff);
   assign pos_m1     = req_position - 7'd1;
   assign len_m1     = len_ff - LW'(1);
   assign idx_next   = idx_ff + LW'(1);
   assign add_bad    = (req_position == 7'd0) || (pos8 > (len8 + 8'd1));
   assign acc_bad    = (req_position == 7'd0) || (pos8 > len8);
   assign is_full    = (len_ff == LW'(pcl_pkg::CAPACITY));

   always_comb begin
      state_in       = state_ff;
      len_in         = len_ff;
      cnt_in         = cnt_ff;
      idx_in         = idx_ff;
      rd_in          = rd_ff;
      wr_addr_in     = wr_addr_ff;
      wr_pend_in     = wr_pend_ff;
      op_add_in      = op_add_ff;
      pos_addr_in    = pos_addr_ff;
      item_in        = item_ff;
      resp_status_in = resp_status_ff;
      mem_req        = '0;
      rsp_load       = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_last_in    = rsp_last_ff;

      case (state_ff)
         pcl_pkg::S_IDLE: begin
            if (req_valid) begin
               op_add_in   = (req_kind == pcl_pkg::KIND_ADD);
               pos_addr_in = pos_m1[AW-1:0];
               item_in     = req_new_item;
               wr_pend_in  = 1'b0;
               case (req_kind)
                  pcl_pkg::KIND_ADD: begin
                     if (add_bad) begin
                        resp_status_in = pcl_pkg::ST_INVALID;
                        state_in       = pcl_pkg::S_RESP;
                     end else if (is_full) begin
                        resp_status_in = pcl_pkg::ST_FULL;
                        state_in       = pcl_pkg::S_RESP;
                     end else begin
                        cnt_in   = LW'(len8 - pos8 + 8'd1);
                        rd_in    = len_m1[AW-1:0];
                        state_in = pcl_pkg::S_SHIFT;
                     end
                  end
                  pcl_pkg::KIND_DELETE: begin
                     if (acc_bad) begin
                        resp_status_in = pcl_pkg::ST_INVALID;
                        state_in       = pcl_pkg::S_RESP;
                     end else begin
                        cnt_in   = LW'(len8 - pos8);
                        rd_in    = req_position[AW-1:0];
                        state_in = pcl_pkg::S_SHIFT;
                     end
                  end
                  pcl_pkg::KIND_GET: begin
                     if (acc_bad) begin
                        resp_status_in = pcl_pkg::ST_INVALID;
                        state_in       = pcl_pkg::S_RESP;
                     end else begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = pos_m1[AW-1:0];
                        state_in        = pcl_pkg::S_GET;
                     end
                  end
                  pcl_pkg::KIND_LIST: begin
                     if (len_ff == '0) begin
                        resp_status_in = pcl_pkg::ST_EMPTY;
                        state_in       = pcl_pkg::S_RESP;
                     end else begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = '0;
                        idx_in          = '0;
                        state_in        = pcl_pkg::S_LIST;
                     end
                  end
                  default: begin
                     state_in = pcl_pkg::S_IDLE;
                  end
               endcase
            end
         end
         pcl_pkg::S_RESP: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_status_in = resp_status_ff;
               rsp_value_in  = 8'd0;
               rsp_last_in   = 1'b1;
               state_in      = pcl_pkg::S_IDLE;
            end
         end
         pcl_pkg::S_GET: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_status_in = pcl_pkg::ST_VALUE;
               rsp_value_in  = rd_data;
               rsp_last_in   = 1'b1;
               state_in      = pcl_pkg::S_IDLE;
            end
         end
         pcl_pkg::S_LIST: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_status_in = pcl_pkg::ST_ELEMENT;
               rsp_value_in  = rd_data;
               rsp_last_in   = (idx_next == len_ff);
               if (idx_next == len_ff) begin
                  state_in = pcl_pkg::S_IDLE;
               end else begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = idx_next[AW-1:0];
                  idx_in          = idx_next;
               end
            end
         end
         pcl_pkg::S_SHIFT: begin
            if (wr_pend_ff) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = wr_addr_ff;
               mem_req.wr_data = rd_data;
            end
            if (cnt_ff != '0) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = rd_ff;
               wr_pend_in      = 1'b1;
               wr_addr_in      = op_add_ff ? (rd_ff + AW'(1)) : (rd_ff - AW'(1));
               rd_in           = op_add_ff ? (rd_ff - AW'(1)) : (rd_ff + AW'(1));
               cnt_in          = cnt_ff - LW'(1);
            end else if (!wr_pend_ff) begin
               if (op_add_ff) begin
                  mem_req.wr_en   = 1'b1;
                  mem_req.wr_addr = pos_addr_ff;
                  mem_req.wr_data = item_ff;
                  len_in          = len_ff + LW'(1);
               end else begin
                  len_in = len_ff - LW'(1);
               end
               state_in = pcl_pkg::S_IDLE;
            end else begin
               wr_pend_in = 1'b0;
            end
         end
         default: begin
            state_in = pcl_pkg::S_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pcl_pkg::S_IDLE;
         len_ff       <= '0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff         <= cnt_in;
      idx_ff         <= idx_in;
      rd_ff          <= rd_in;
      wr_addr_ff     <= wr_addr_in;
      op_add_ff      <= op_add_in;
      pos_addr_ff    <= pos_addr_in;
      item_ff        <= item_in;
      resp_status_ff <= resp_status_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_last   = rsp_last_ff;

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LW'(pcl_pkg::CAPACITY))
      else $error("list length above capacity");

   a_len_only_on_shift: assert property (@(posedge clock) disable iff (reset)
      state_ff != pcl_pkg::S_SHIFT |=> $stable(len_ff))
      else $error("list length changed outside add or delete");

   a_no_beat_while_shift: assert property (@(posedge clock) disable iff (reset)
      state_ff == pcl_pkg::S_SHIFT |-> !rsp_load)
      else $error("response loaded during add or delete");

   a_err_zero_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == pcl_pkg::ST_INVALID
                       || rsp_status_ff == pcl_pkg::ST_FULL
                       || rsp_status_ff == pcl_pkg::ST_EMPTY)
      |-> (rsp_value_ff == 8'd0) && rsp_last_ff)
      else $error("error beat with non-zero value or without last");

endmodule

>>> dv/pcl_list_check.sv
// pcl_list_check: watches both channels of positional_char_list, keeps a
// shadow copy of the list, predicts every response beat and compares it
// depends on pcl_pkg
module pcl_list_check (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [1:0] req_kind,
   input  logic [6:0] req_position,
   input  logic [7:0] req_new_item,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [2:0] rsp_status,
   input  logic [7:0] rsp_value,
   input  logic       rsp_last,
   output int         fail_count,
   output int         beats_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] value;
      logic       last;
   } list_beat_type;

   logic [7:0]    shadow_items [pcl_pkg::CAPACITY];
   int unsigned   shadow_len;
   list_beat_type owed_beats [$];

   initial begin
      fail_count = 0;
      beats_owed = 0;
      shadow_len = 0;
   end

   task automatic report_mismatch(input string what);
      if (fail_count < 50) begin
         $display("[%0t] mismatch: %s", $time, what);
      end
      fail_count++;
   endtask

   task automatic owe(input logic [2:0] status, input logic [7:0] value, input logic last);
      list_beat_type b;
      b.status = status;
      b.value  = value;
      b.last   = last;
      owed_beats.push_back(b);
   endtask

   task automatic apply_request(input logic [1:0] kind, input logic [6:0] position,
                                input logic [7:0] item);
      int unsigned p;
      p = position;
      case (kind)
         pcl_pkg::KIND_LIST: begin
            if (shadow_len == 0) begin
               owe(pcl_pkg::ST_EMPTY, 8'h00, 1'b1);
            end else begin
               for (int unsigned i = 0; i < shadow_len; i++) begin
                  owe(pcl_pkg::ST_ELEMENT, shadow_items[i], (i + 1 == shadow_len));
               end
            end
         end
         pcl_pkg::KIND_ADD: begin
            if (p == 0 || p > shadow_len + 1) begin
               owe(pcl_pkg::ST_INVALID, 8'h00, 1'b1);
            end else if (shadow_len >= pcl_pkg::CAPACITY) begin
               owe(pcl_pkg::ST_FULL, 8'h00, 1'b1);
            end else begin
               for (int unsigned i = shadow_len; i > p - 1; i--) begin
                  shadow_items[i] = shadow_items[i - 1];
               end
               shadow_items[p - 1] = item;
               shadow_len++;
            end
         end
         default: begin
            if (p == 0 || p > shadow_len) begin
               owe(pcl_pkg::ST_INVALID, 8'h00, 1'b1);
            end else if (kind == pcl_pkg::KIND_GET) begin
               owe(pcl_pkg::ST_VALUE, shadow_items[p - 1], 1'b1);
            end else begin
               for (int unsigned i = p - 1; i + 1 < shadow_len; i++) begin
                  shadow_items[i] = shadow_items[i + 1];
               end
               shadow_len--;
            end
         end
      endcase
   endtask

   always @(posedge clock) begin : watch
      list_beat_type want;
      if (reset) begin
         shadow_len = 0;
         owed_beats.delete();
      end else begin
         // response first: a beat can never belong to a request taken at the same edge
         if (rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
            if (owed_beats.size() == 0) begin
               report_mismatch($sformatf("unexpected beat st=%0d value=%02h last=%b",
                                         rsp_status, rsp_value, rsp_last));
            end else begin
               want = owed_beats.pop_front();
               if (rsp_status !== want.status) begin
                  report_mismatch($sformatf("st got %0d want %0d", rsp_status, want.status));
               end
               if (rsp_value !== want.value) begin
                  report_mismatch($sformatf("value got %02h want %02h",
                                            rsp_value, want.value));
               end
               if (rsp_last !== want.last) begin
                  report_mismatch($sformatf("last got %b want %b", rsp_last, want.last));
               end
            end
         end
         if (req_valid === 1'b1 && req_ready === 1'b1) begin
            apply_request(req_kind, req_position, req_new_item);
         end
      end
      beats_owed <= owed_beats.size();
   end

endmodule

>>> dv/testbench.sv
// testbench: drives directed and random list operations into
// positional_char_list and gives the verdict
// depends on pcl_pkg, positional_char_list and pcl_list_check
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 3000;
   localparam int DRAIN_CYCLES = 80;
   localparam int RANDOM_ITEMS = 258;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_kind = pcl_pkg::KIND_LIST;
   logic [6:0] req_position = 7'd0;
   logic [7:0] req_new_item = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [2:0] rsp_status;
   logic [7:0] rsp_value;
   logic       rsp_last;

   int fail_count;
   int beats_owed;
   int req_idle_pct = 34;
   int rsp_idle_pct = 81;
   int len_est = 0;
   int full_hits = 0;
   int sent = 0;
   int quiet_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   positional_char_list dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_kind    (req_kind),
      .req_position(req_position),
      .req_new_item(req_new_item),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_status  (rsp_status),
      .rsp_value   (rsp_value),
      .rsp_last    (rsp_last)
   );

   pcl_list_check list_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_kind    (req_kind),
      .req_position(req_position),
      .req_new_item(req_new_item),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_status  (rsp_status),
      .rsp_value   (rsp_value),
      .rsp_last    (rsp_last),
      .fail_count  (fail_count),
      .beats_owed  (beats_owed)
   );

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic send_req(input logic [1:0] k, input logic [6:0] p, input logic [7:0] d);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_kind     <= k;
      req_position <= p;
      req_new_item <= d;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // rough length tracking, only used to steer the random mix
      if (k == pcl_pkg::KIND_ADD && p >= 1 && p <= len_est + 1) begin
         if (len_est < pcl_pkg::CAPACITY) len_est++;
         else full_hits++;
      end else if (k == pcl_pkg::KIND_DELETE && p >= 1 && p <= len_est) begin
         len_est--;
      end
      sent++;
      if (sent == 100) begin
         req_idle_pct = 81;
         rsp_idle_pct = 34;
      end else if (sent == 200) begin
         req_idle_pct = 0;
         rsp_idle_pct = 0;
      end
   endtask

   initial begin
      int         roll;
      int         p;
      logic [1:0] k;
      bit         growing;
      growing = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_req(pcl_pkg::KIND_LIST,   7'd0,   8'h00);
      send_req(pcl_pkg::KIND_GET,    7'd0,   8'h00);
      send_req(pcl_pkg::KIND_DELETE, 7'd1,   8'h00);
      send_req(pcl_pkg::KIND_ADD,    7'd0,   8'h33);
      send_req(pcl_pkg::KIND_ADD,    7'd2,   8'h44);
      send_req(pcl_pkg::KIND_ADD,    7'd1,   8'h00);
      send_req(pcl_pkg::KIND_ADD,    7'd2,   8'hFF);
      send_req(pcl_pkg::KIND_ADD,    7'd1,   8'h5A);
      send_req(pcl_pkg::KIND_ADD,    7'd5,   8'h11);
      send_req(pcl_pkg::KIND_ADD,    7'd127, 8'h80);
      send_req(pcl_pkg::KIND_GET,    7'd1,   8'hFF);
      send_req(pcl_pkg::KIND_GET,    7'd3,   8'h00);
      send_req(pcl_pkg::KIND_GET,    7'd4,   8'h00);
      send_req(pcl_pkg::KIND_GET,    7'd127, 8'h00);
      send_req(pcl_pkg::KIND_DELETE, 7'd0,   8'h00);
      send_req(pcl_pkg::KIND_DELETE, 7'd4,   8'h00);
      send_req(pcl_pkg::KIND_LIST,   7'd127, 8'hFF);
      send_req(pcl_pkg::KIND_DELETE, 7'd2,   8'h00);
      send_req(pcl_pkg::KIND_LIST,   7'd0,   8'h00);
      send_req(pcl_pkg::KIND_DELETE, 7'd1,   8'h00);
      send_req(pcl_pkg::KIND_DELETE, 7'd1,   8'h00);
      send_req(pcl_pkg::KIND_LIST,   7'd64,  8'h00);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (growing && full_hits >= 3) begin
            growing   = 1'b0;
            full_hits = 0;
         end else if (!growing && len_est == 0) begin
            growing = 1'b1;
         end
         roll = $urandom_range(99);
         if (roll < 8) begin
            k = 2'($urandom_range(3));
            p = $urandom_range(1) ? $urandom_range(127) : len_est + 1 + $urandom_range(1);
         end else if (roll < (growing ? 70 : 22)) begin
            k = pcl_pkg::KIND_ADD;
            p = $urandom_range(len_est + 1, 1);
         end else if (roll < (growing ? 78 : 74)) begin
            k = pcl_pkg::KIND_DELETE;
            p = (len_est == 0) ? 1 : $urandom_range(len_est, 1);
         end else if (roll < 92) begin
            k = pcl_pkg::KIND_GET;
            p = (len_est == 0) ? 1 : $urandom_range(len_est, 1);
         end else begin
            k = pcl_pkg::KIND_LIST;
            p = $urandom_range(127);
         end
         send_req(k, 7'(p), 8'($urandom_range(255)));
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (beats_owed != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
